// File: rtl/lzw_pkg.sv
// Shared widths, limits and bus types of the LZW compressor.
package lzw_pkg;

  localparam int CODE_W     = 12;
  localparam int SYM_W      = 8;
  localparam int KEY_W      = CODE_W + SYM_W;
  localparam int ALPHA_W    = 9;
  localparam int NEXT_W     = 13;
  localparam int DICT_DEPTH = 4096;
  localparam int GROUP_SIZE = 64;
  localparam int ALPHA_LIMIT = 511;

  // Lookup broadcast to every dictionary cell when an item is accepted
  typedef struct packed {
    logic                 en;
    logic [KEY_W-1:0]     key;
    logic [ALPHA_W-1:0]   alpha_count;
    logic [NEXT_W-1:0]    next_code;
  } lzw_query_t;

  // New dictionary entry
  typedef struct packed {
    logic                 en;
    logic [CODE_W-1:0]    index;
    logic [KEY_W-1:0]     key;
  } lzw_write_t;

  // Match report: at most one cell hits, so codes combine by OR
  typedef struct packed {
    logic                 hit;
    logic [CODE_W-1:0]    code;
  } lzw_match_t;

endpackage

// File: rtl/lzw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lzw_cell.sv
// One dictionary cell: holds the key of the phrase with a fixed code.
module lzw_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  lzw_pkg::lzw_query_t query,
  input  lzw_pkg::lzw_write_t wr,
  output lzw_pkg::lzw_match_t match
);

  localparam logic [lzw_pkg::CODE_W-1:0] CODE   = lzw_pkg::CODE_W'(IDX);
  localparam logic [lzw_pkg::NEXT_W-1:0] CODE_N = lzw_pkg::NEXT_W'(IDX);

  logic [lzw_pkg::KEY_W-1:0] key;
  logic                      hit;
  logic                      live;

  // entry belongs to the current message only between the terminator and next_code
  assign live = (CODE_N > {{(lzw_pkg::NEXT_W - lzw_pkg::ALPHA_W){1'b0}}, query.alpha_count})
             && (CODE_N < query.next_code);

  // store the key when this code is assigned
  always_ff @(posedge clk) begin
    if (wr.en && (wr.index == CODE)) begin
      key <= wr.key;
    end
  end

  // compare against the lookup once per accepted word
  always_ff @(posedge clk) begin
    if (query.en) begin
      hit <= live && (key == query.key);
    end
  end

  assign match.hit  = hit;
  assign match.code = hit ? CODE : '0;

endmodule

// File: rtl/lzw_group.sv
// A run of dictionary cells with a registered OR of their match reports.
module lzw_group #(
  parameter int BASE  = 0,
  parameter int COUNT = 64
) (
  input  logic                clk,
  input  lzw_pkg::lzw_query_t query,
  input  lzw_pkg::lzw_write_t wr,
  output lzw_pkg::lzw_match_t match
);

  lzw_pkg::lzw_match_t cell_match [COUNT];
  lzw_pkg::lzw_match_t match_or;

  // row of cells, one per code
  for (genvar k = 0; k < COUNT; k++) begin : g_cell
    lzw_cell #(
      .IDX (BASE + k)
    ) u_cell (
      .clk   (clk),
      .query (query),
      .wr    (wr),
      .match (cell_match[k])
    );
  end

  // combine the cell reports
  always_comb begin
    match_or = '0;
    for (int k = 0; k < COUNT; k++) begin
      match_or.hit  = match_or.hit  | cell_match[k].hit;
      match_or.code = match_or.code | cell_match[k].code;
    end
  end

  always_ff @(posedge clk) begin
    match <= match_or;
  end

endmodule

// File: rtl/lzw_compressor.sv
// LZW compressor top level: control, symbol map and the row of dictionary cells.
// Usage: a word is taken when start is high and busy is low; results appear on
// code/last for exactly one cycle with valid high and cannot be stalled. Start and
// alphabet words leave busy low. A data byte is handled in steps: the pair (current
// code, byte) is compared in every dictionary cell at once, the reports are ORed over
// each group of 64 cells and then over the groups, and the last step decides, emits
// and inserts; both reduction levels are registered. An end word gives the code of
// the open phrase, if any, and then the terminator in the cycle after it. Dictionary
// cells hold MAX_CODES entries at most (4096 at most); no clearing pass is needed
// after reset or start, since only codes written in the current message are live.
module lzw_compressor #(
  parameter int MAX_CODES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  symbol,
  output logic        valid,
  output logic [11:0] code,
  output logic        last
);

  localparam int NCELL  = (MAX_CODES < lzw_pkg::DICT_DEPTH) ? MAX_CODES : lzw_pkg::DICT_DEPTH;
  localparam int NGROUP = (NCELL + lzw_pkg::GROUP_SIZE - 1) / lzw_pkg::GROUP_SIZE;
  localparam logic [lzw_pkg::NEXT_W-1:0] NCELL_N = lzw_pkg::NEXT_W'(NCELL);
  localparam logic [lzw_pkg::ALPHA_W-1:0] ALPHA_MAX = lzw_pkg::ALPHA_W'(lzw_pkg::ALPHA_LIMIT);
  localparam int SYM_N  = 1 << lzw_pkg::SYM_W;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_ALPHA = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;
  localparam logic [1:0] ACT_END   = 2'd3;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAP    = 3'd1;
  localparam logic [2:0] S_GROUP  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_TERM   = 3'd4;

  logic [2:0]                     state, state_next;
  logic [lzw_pkg::ALPHA_W-1:0]    alpha_count, alpha_count_next;
  logic [lzw_pkg::NEXT_W-1:0]     next_code, next_code_next;
  logic [lzw_pkg::CODE_W-1:0]     phrase_code, phrase_code_next;
  logic                           phrase_open, phrase_open_next;
  logic                           valid_next, last_next;
  logic [lzw_pkg::CODE_W-1:0]     code_next;
  logic [lzw_pkg::SYM_W-1:0]      byte_sym;
  logic [lzw_pkg::CODE_W-1:0]     byte_code, byte_code_next;
  logic                           map_known;
  logic [SYM_N-1:0]               known;
  logic [lzw_pkg::ALPHA_W-1:0]    map_rdata;
  logic                           accept;
  logic                           alpha_ok;
  logic                           map_we;
  logic [lzw_pkg::NEXT_W-1:0]     alpha_inc;
  logic [lzw_pkg::NEXT_W-1:0]     nc_eff;
  lzw_pkg::lzw_query_t            query;
  lzw_pkg::lzw_write_t            wr;
  lzw_pkg::lzw_match_t            grp_match [NGROUP];
  lzw_pkg::lzw_match_t            top_or;
  lzw_pkg::lzw_match_t            found;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign alpha_inc = {{(lzw_pkg::NEXT_W - lzw_pkg::ALPHA_W){1'b0}}, alpha_count} + 1'b1;
  assign alpha_ok  = !phrase_open && (next_code <= alpha_inc) && (alpha_count < ALPHA_MAX);
  assign map_we    = accept && (action == ACT_ALPHA) && alpha_ok;

  // symbol map: RAM plus per-symbol known bits cleared at once
  lzw_ram #(
    .WIDTH (lzw_pkg::ALPHA_W),
    .DEPTH (SYM_N)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (symbol),
    .wdata (alpha_count),
    .raddr (symbol),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      known <= '0;
    end else if (accept && (action == ACT_START)) begin
      known <= '0;
    end else if (map_we) begin
      known[symbol] <= 1'b1;
    end
  end

  // hold the byte and its map status for the data pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_sym  <= symbol;
      map_known <= known[symbol];
    end
    if (state == S_MAP) begin
      byte_code <= byte_code_next;
    end
  end

  // the NUL byte always maps to the terminator; unknown bytes map to zero
  always_comb begin
    if (byte_sym == '0) begin
      byte_code_next = lzw_pkg::CODE_W'(alpha_count);
    end else if (map_known) begin
      byte_code_next = lzw_pkg::CODE_W'(map_rdata);
    end else begin
      byte_code_next = '0;
    end
  end

  // lookup broadcast to the cells
  assign query.en          = accept;
  assign query.key         = {phrase_code, symbol};
  assign query.alpha_count = alpha_count;
  assign query.next_code   = next_code;

  // row of dictionary cells in groups
  for (genvar g = 0; g < NGROUP; g++) begin : g_group
    localparam int BASE = g * lzw_pkg::GROUP_SIZE;
    localparam int CNT  = ((NCELL - BASE) < lzw_pkg::GROUP_SIZE) ?
                          (NCELL - BASE) : lzw_pkg::GROUP_SIZE;
    lzw_group #(
      .BASE  (BASE),
      .COUNT (CNT)
    ) u_group (
      .clk   (clk),
      .query (query),
      .wr    (wr),
      .match (grp_match[g])
    );
  end

  // combine the group reports
  always_comb begin
    top_or = '0;
    for (int g = 0; g < NGROUP; g++) begin
      top_or.hit  = top_or.hit  | grp_match[g].hit;
      top_or.code = top_or.code | grp_match[g].code;
    end
  end

  always_ff @(posedge clk) begin
    found <= top_or;
  end

  // raise next_code to the first phrase code before it is used
  assign nc_eff = (next_code <= {{(lzw_pkg::NEXT_W - lzw_pkg::ALPHA_W){1'b0}}, alpha_count}) ?
                  alpha_inc : next_code;

  // control: sequence items, update phrase state, drive results and inserts
  always_comb begin
    state_next       = state;
    alpha_count_next = alpha_count;
    next_code_next   = next_code;
    phrase_code_next = phrase_code;
    phrase_open_next = phrase_open;
    valid_next       = 1'b0;
    code_next        = code;
    last_next        = 1'b0;
    wr.en            = 1'b0;
    wr.index         = nc_eff[lzw_pkg::CODE_W-1:0];
    wr.key           = {phrase_code, byte_sym};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_START: begin
              alpha_count_next = '0;
              next_code_next   = lzw_pkg::NEXT_W'(1);
              phrase_code_next = '0;
              phrase_open_next = 1'b0;
            end
            ACT_ALPHA: begin
              if (alpha_ok) begin
                alpha_count_next = alpha_count + 1'b1;
                next_code_next   = alpha_inc + 1'b1;
              end
            end
            ACT_DATA: begin
              state_next = S_MAP;
            end
            ACT_END: begin
              phrase_open_next = 1'b0;
              valid_next       = 1'b1;
              if (phrase_open) begin
                code_next  = phrase_code;
                state_next = S_TERM;
              end else begin
                code_next = lzw_pkg::CODE_W'(alpha_count);
                last_next = 1'b1;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_MAP: begin
        state_next = S_GROUP;
      end
      S_GROUP: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next     = S_IDLE;
        next_code_next = nc_eff;
        if (!phrase_open) begin
          phrase_code_next = byte_code;
          phrase_open_next = 1'b1;
        end else if (found.hit) begin
          phrase_code_next = found.code;
        end else begin
          if (nc_eff < NCELL_N) begin
            wr.en          = 1'b1;
            next_code_next = nc_eff + 1'b1;
          end
          valid_next       = 1'b1;
          code_next        = phrase_code;
          phrase_code_next = byte_code;
        end
      end
      S_TERM: begin
        state_next = S_IDLE;
        valid_next = 1'b1;
        code_next  = lzw_pkg::CODE_W'(alpha_count);
        last_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      alpha_count <= '0;
      next_code   <= '0;
      phrase_code <= '0;
      phrase_open <= 1'b0;
      valid       <= 1'b0;
    end else begin
      state       <= state_next;
      alpha_count <= alpha_count_next;
      next_code   <= next_code_next;
      phrase_code <= phrase_code_next;
      phrase_open <= phrase_open_next;
      valid       <= valid_next;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    code <= code_next;
    last <= last_next;
  end

`ifndef SYNTHESIS
  a_term_closes: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> !phrase_open)
    else $error("terminator sent while a phrase is still open");

  a_next_bound: assert property (@(posedge clk) disable iff (rst)
    next_code <= NCELL_N)
    else $error("next_code ran past the dictionary size");

  a_found_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) && found.hit |->
      ({1'b0, found.code} > {{(lzw_pkg::NEXT_W - lzw_pkg::ALPHA_W){1'b0}}, alpha_count})
      && ({1'b0, found.code} < next_code))
    else $error("dictionary match outside the live code range");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(busy) || $past(start))
    else $error("result word without an item at work");
`endif

endmodule
